### design/table_inverse_interpolator_macros.svh
// Assertion macros shared by the table inverse interpolator RTL.
// The surrounding module must provide signals named clk and rst.
`ifndef TABLE_INVERSE_INTERPOLATOR_MACROS_SVH
`define TABLE_INVERSE_INTERPOLATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TII_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TII_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TII_ASSERT_SAME(lbl, ante, cons, msg)
`define TII_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/tii_pkg.sv
`default_nettype none

package tii_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int KEY_W   = 31;
  localparam int PARAM_W = 17;
  localparam int DIST_W  = 32;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 32;
  localparam int ENTRY_W = KEY_W + PARAM_W;
  localparam int PROD_W  = KEY_W + PARAM_W;

  localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = COUNT_W'(2);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_SPAN_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_INTERP,
    STATUS_BELOW,
    STATUS_PAST,
    STATUS_FLAT
  } tii_status_t;

  typedef struct packed {
    logic                     command;
    logic [SLOT_W-1:0]        entry_index;
    logic signed [DIST_W-1:0] distance_value;
    logic [PARAM_W-1:0]       param_value;
  } tii_item_t;

  typedef struct packed {
    logic [PARAM_W-1:0] param_out;
    tii_status_t        status;
  } tii_result_t;

endpackage

`default_nettype wire

### design/table_inverse_interpolator.sv
// Table inverse interpolator: maps a Q16.16 distance to a Q1.16 parameter.
// Items enter on start while busy is low. A load beat writes one table pair
// in its accept cycle and returns nothing; busy stays low, so a new item may
// follow in the next cycle. A query beat returns one result on result,
// marked by done for exactly one cycle; the receiver cannot hold it off.
// Queries at or below zero, or at or beyond span_length, answer in the cycle
// after acceptance. Other queries run a binary search over the table RAM,
// a probe read and a compare per step for at most ceil(log2(N-1)) steps,
// where N is the clamped entry count, then two RAM reads for the bracket, a
// multiply, and a 17-step restoring divider. Done rises in the same cycle
// that busy falls. A bracket whose upper key is not above its lower key
// skips the multiply and divider. The search uses the single RAM read port.
// Busy stays high for the whole of a searched query, so one query runs at a
// time. The configuration channel is always ready. The user must write it
// only while idle; the block itself does not enforce this.
// Synchronous reset sets entry_count to 2 and span_length to 0; the table
// contents are not cleared and must be loaded before use.
`default_nettype none
`include "table_inverse_interpolator_macros.svh"

module table_inverse_interpolator
  import tii_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tii_item_t        item,
  output logic                  done,
  output tii_result_t           result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_RDLO,
    S_RDHI,
    S_PREP,
    S_MUL,
    S_DIVGO,
    S_DIV
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] entry_count;
  logic [KEY_W-1:0]   span_length;

  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic [AW-1:0]      mid;
  logic [KEY_W-1:0]   qd;
  logic [KEY_W-1:0]   key_lo;
  logic [KEY_W-1:0]   key_hi;
  logic [PARAM_W-1:0] t_lo;
  logic [PARAM_W-1:0] t_hi;
  logic [KEY_W-1:0]   den;
  logic [KEY_W-1:0]   num;
  logic [PARAM_W-1:0] diff;
  logic               ascend;
  logic [PROD_W-1:0]  prod;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [PARAM_W-1:0] rd_param;

  logic [31:0]        cnt_wide;
  logic [31:0]        used_wide;
  logic [31:0]        slot_wide;
  logic [AW-1:0]      hi_init;
  logic [AW:0]        mid_sum;
  logic [AW-1:0]      mid_now;
  logic               more;
  logic               accept;
  logic               below;
  logic               past;
  logic [KEY_W-1:0]   load_key;
  logic [PARAM_W-1:0] load_param;
  logic [KEY_W-1:0]   den_now;
  logic [KEY_W-1:0]   num_raw;
  logic [KEY_W-1:0]   num_now;

  logic               div_start;
  logic               div_done;
  logic [PARAM_W-1:0] quotient;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign rd_key    = ram_rdata[ENTRY_W-1:PARAM_W];
  assign rd_param  = ram_rdata[PARAM_W-1:0];
  assign div_start = (state == S_DIVGO);

  always_comb begin
    cnt_wide = 32'(entry_count);
    if (cnt_wide < 32'd2) begin
      used_wide = 32'd2;
    end else if (cnt_wide > 32'(TABLE_DEPTH)) begin
      used_wide = 32'(TABLE_DEPTH);
    end else begin
      used_wide = cnt_wide;
    end
    hi_init = AW'(used_wide - 32'd1);

    mid_sum = {1'b0, lo} + {1'b0, hi};
    mid_now = mid_sum[AW:1];
    more    = (hi - lo) > AW'(1);

    slot_wide  = 32'(item.entry_index);
    ram_waddr  = slot_wide[AW-1:0];
    load_key   = item.distance_value[DIST_W-1] ? '0 : item.distance_value[KEY_W-1:0];
    load_param = (item.param_value > ONE_Q16) ? ONE_Q16 : item.param_value;
    ram_wdata  = {load_key, load_param};
    ram_we     = accept && (item.command == CMD_LOAD) && (slot_wide < 32'(TABLE_DEPTH));

    below = item.distance_value <= 32'sd0;
    past  = item.distance_value >= $signed({1'b0, span_length});

    den_now = key_hi - key_lo;
    num_raw = (qd > key_lo) ? (qd - key_lo) : '0;
    num_now = (num_raw > den_now) ? den_now : num_raw;
  end

  always_comb begin
    unique case (state)
      S_PROBE: ram_raddr = more ? mid_now : lo;
      S_RDLO:  ram_raddr = hi;
      default: ram_raddr = lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      entry_count <= ENTRY_COUNT_RESET;
      span_length <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
          CFG_SPAN_LENGTH: span_length <= cfg_data[KEY_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.command == CMD_QUERY) begin
            if (below) begin
              result <= '{param_out: '0, status: STATUS_BELOW};
              done   <= 1'b1;
            end else if (past) begin
              result <= '{param_out: ONE_Q16, status: STATUS_PAST};
              done   <= 1'b1;
            end else begin
              qd    <= item.distance_value[KEY_W-1:0];
              lo    <= '0;
              hi    <= hi_init;
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (more) begin
            mid   <= mid_now;
            state <= S_CMP;
          end else begin
            state <= S_RDLO;
          end
        end
        S_CMP: begin
          if (rd_key < qd) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
          state <= S_PROBE;
        end
        S_RDLO: begin
          key_lo <= rd_key;
          t_lo   <= rd_param;
          state  <= S_RDHI;
        end
        S_RDHI: begin
          key_hi <= rd_key;
          t_hi   <= rd_param;
          state  <= S_PREP;
        end
        S_PREP: begin
          if (key_hi <= key_lo) begin
            result <= '{param_out: t_lo, status: STATUS_FLAT};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            den    <= den_now;
            num    <= num_now;
            ascend <= t_hi >= t_lo;
            diff   <= (t_hi >= t_lo) ? (t_hi - t_lo) : (t_lo - t_hi);
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(diff) * PROD_W'(num);
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            result <= '{param_out: ascend ? (t_lo + quotient) : (t_lo - quotient),
                        status: STATUS_INTERP};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tii_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tii_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (den),
    .done    (div_done),
    .quotient(quotient)
  );

  `TII_ASSERT_SAME(a_bracket_order, state == S_PROBE, lo < hi, "search bracket collapsed")
  `TII_ASSERT_SAME(a_div_in_wait, div_done, state == S_DIV, "divider finished outside wait")
  `TII_ASSERT_NEXT(a_load_no_busy, accept && item.command == CMD_LOAD, !busy, "load made busy")
  `TII_ASSERT_SAME(a_done_cause, done, $past(busy) || $past(start), "result without an item")

endmodule

`default_nettype wire

### design/tii_ram.sv
`default_nettype none

module tii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/tii_divider.sv
`default_nettype none

module tii_divider
  import tii_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [PROD_W-1:0]  dividend,
  input  wire logic [KEY_W-1:0]   divisor,
  output logic                    done,
  output logic      [PARAM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(PARAM_W);

  // The quotient is known to fit in PARAM_W bits, so the upper dividend
  // bits already lie below the divisor and only PARAM_W steps are needed.
  logic [KEY_W-1:0]   rem;
  logic [PARAM_W-1:0] low;
  logic [KEY_W-1:0]   dsr;
  logic [CNT_W-1:0]   count;
  logic               running;
  logic [KEY_W:0]     shifted;
  logic [KEY_W:0]     trial;
  logic               fits;

  always_comb begin
    shifted = {rem, low[PARAM_W-1]};
    trial   = shifted - {1'b0, dsr};
    fits    = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= dividend[PROD_W-1:PARAM_W];
        low     <= dividend[PARAM_W-1:0];
        dsr     <= divisor;
        count   <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem      <= fits ? trial[KEY_W-1:0] : shifted[KEY_W-1:0];
        low      <= {low[PARAM_W-2:0], 1'b0};
        quotient <= {quotient[PARAM_W-2:0], fits};
        count    <= count + CNT_W'(1);
        if (count == CNT_W'(PARAM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### dv/table_inverse_interpolator_checker.sv
`default_nettype none

module table_inverse_interpolator_checker
  import tii_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire tii_item_t        item,
  input  wire logic             done,
  input  wire tii_result_t      result,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output int                    check_errors,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_W-1:0]   key_copy [TABLE_DEPTH];
  logic [PARAM_W-1:0] t_copy [TABLE_DEPTH];
  logic [COUNT_W-1:0] count_copy = ENTRY_COUNT_RESET;
  logic [KEY_W-1:0]   span_copy = '0;
  tii_result_t        owed_t [$];

  function automatic int unsigned active_entries();
    int unsigned n;
    n = count_copy;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic tii_result_t interpolate_t(input logic signed [DIST_W-1:0] d);
    tii_result_t        r;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        mid;
    logic [DIST_W-1:0]  dd;
    logic [KEY_W-1:0]   d1;
    logic [KEY_W-1:0]   d2;
    logic [KEY_W-1:0]   num;
    logic [KEY_W-1:0]   den;
    logic [PARAM_W-1:0] t1;
    logic [PARAM_W-1:0] t2;
    logic [PARAM_W-1:0] diff;
    logic [63:0]        q;
    if (d <= 0) begin
      r.param_out = '0;
      r.status = STATUS_BELOW;
      return r;
    end
    dd = d;
    if (dd >= {1'b0, span_copy}) begin
      r.param_out = ONE_Q16;
      r.status = STATUS_PAST;
      return r;
    end
    lo = 0;
    hi = active_entries() - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if ({1'b0, key_copy[mid]} < dd) lo = mid;
      else hi = mid;
    end
    d1 = key_copy[lo];
    d2 = key_copy[hi];
    t1 = t_copy[lo];
    t2 = t_copy[hi];
    if (d2 <= d1) begin
      r.param_out = t1;
      r.status = STATUS_FLAT;
      return r;
    end
    den = d2 - d1;
    if (dd < {1'b0, d1}) num = '0;
    else if ((dd - {1'b0, d1}) > {1'b0, den}) num = den;
    else num = KEY_W'(dd - {1'b0, d1});
    diff = (t2 >= t1) ? t2 - t1 : t1 - t2;
    q = (64'(diff) * 64'(num)) / 64'(den);
    r.param_out = (t2 >= t1) ? t1 + PARAM_W'(q) : t1 - PARAM_W'(q);
    r.status = STATUS_INTERP;
    return r;
  endfunction

  always @(posedge clk) begin
    tii_result_t want;
    if (rst) begin
      count_copy = ENTRY_COUNT_RESET;
      span_copy = '0;
      owed_t.delete();
    end else begin
      if (done) begin
        if (owed_t.size() == 0) begin
          $error("unexpected result beat: param_out %0d, status %0d",
                 result.param_out, result.status);
          check_errors++;
        end else begin
          want = owed_t.pop_front();
          if (result.param_out !== want.param_out) begin
            $error("param_out mismatch: expected %0d, actual %0d",
                   want.param_out, result.param_out);
            check_errors++;
          end
          if (result.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, result.status);
            check_errors++;
          end
        end
      end
      if (start && !busy) begin
        if (item.command == CMD_QUERY) begin
          owed_t = {owed_t, interpolate_t(item.distance_value)};
        end else if (int'(item.entry_index) < TABLE_DEPTH) begin
          key_copy[item.entry_index] = (item.distance_value < 0) ? KEY_W'(0) :
                                       item.distance_value[KEY_W-1:0];
          t_copy[item.entry_index] = (item.param_value > ONE_Q16) ? ONE_Q16 :
                                     item.param_value;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ENTRY_COUNT) count_copy = cfg_data[COUNT_W-1:0];
        else span_copy = cfg_data[KEY_W-1:0];
      end
    end
    results_owed = owed_t.size();
  end

endmodule

`default_nettype wire

### dv/table_inverse_interpolator_tb.sv
`default_nettype none

module table_inverse_interpolator_tb
  import tii_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_BUDGET    = 750;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  tii_item_t        item = '0;
  logic             done;
  tii_result_t      result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = CFG_ENTRY_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  int check_errors;
  int results_owed;
  int quiet_cycles = 0;
  int load_beats = 0;
  int query_beats = 0;
  int settings_run = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  table_inverse_interpolator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  table_inverse_interpolator_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) lookup_check (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .check_errors(check_errors),
    .results_owed(results_owed)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without any beat", WATCHDOG_LIMIT);
      $display("table_inverse_interpolator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A beat is taken at the rising edge after a falling edge that saw busy low.
  task automatic send_item(input tii_item_t beat);
    start <= 1'b1;
    item <= beat;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (beat.command == CMD_LOAD) load_beats++;
    else query_beats++;
  endtask

  task automatic send_fields(input logic cmd, input logic [SLOT_W-1:0] slot,
                             input logic [DIST_W-1:0] dist_value,
                             input logic [PARAM_W-1:0] t);
    tii_item_t beat;
    beat.command = cmd;
    beat.entry_index = slot;
    beat.distance_value = dist_value;
    beat.param_value = t;
    send_item(beat);
  endtask

  task automatic pause_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(negedge clk); while (results_owed != 0 || busy);
    @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data, input bit idle_on);
    if (idle_on && $urandom_range(0, 1) == 0) repeat ($urandom_range(1, 6)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_entry_count();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 60) n = $urandom_range(2, 12);
    else if (r < 70) n = $urandom_range(0, 1);
    else if (r < 85) n = $urandom_range(13, 64);
    else if (r < 98) n = $urandom_range(65, 200);
    else n = $urandom_range(201, 300);
    return {21'($urandom), 11'(n)};
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] count_data, input int queries,
                           input bit idle_on);
    int unsigned       n;
    int unsigned       mode;
    int unsigned       step_cap;
    int unsigned       acc;
    int unsigned       span31;
    int unsigned       hi_end;
    int unsigned       pick;
    longint            top_key;
    logic [DIST_W-1:0] plan_key [TABLE_DEPTH];
    logic [PARAM_W-1:0] plan_t [TABLE_DEPTH];
    logic [CFG_W-1:0]  span_data;
    logic [DIST_W-1:0] query_dist;
    n = count_data[COUNT_W-1:0];
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    mode = $urandom_range(0, 7);
    step_cap = (mode < 3) ? 16 : (mode < 5) ? 65536 : 32'h7FFF_0000 / n;
    acc = $urandom_range(0, 4096);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 7) != 0) acc += $urandom_range(1, step_cap);
      plan_key[i] = acc;
      if (mode == 7) plan_key[i] = $urandom;
      else if ($urandom_range(0, 31) == 0) plan_key[i] = -$urandom_range(1, 4096);
      plan_t[i] = ($urandom_range(0, 15) == 0) ? PARAM_W'($urandom_range(65537, 131071)) :
                                                 PARAM_W'($urandom_range(0, 65536));
    end
    case ($urandom_range(0, 9))
      0: span31 = 0;
      1: span31 = 32'h7FFF_FFFF;
      2: span31 = $urandom_range(0, 32'h7FFF_FFFF);
      default: begin
        top_key = longint'(acc) + longint'($urandom_range(0, 32'h2_0000));
        span31 = (top_key > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(top_key);
      end
    endcase
    span_data = {1'($urandom_range(0, 1)), span31[30:0]};
    hi_end = (acc > span31) ? acc : span31;
    if (hi_end < 32'h7FFF_FF00) hi_end += 32'h100;

    write_reg(CFG_ENTRY_COUNT, count_data, idle_on);
    write_reg(CFG_SPAN_LENGTH, span_data, idle_on);

    for (int i = 0; i < n; i++) begin
      if (idle_on && $urandom_range(0, 5) == 0) pause_burst();
      send_fields(CMD_LOAD, SLOT_W'(i), plan_key[i], plan_t[i]);
    end

    for (int k = 0; k < queries; k++) begin
      if (idle_on && $urandom_range(0, 4) == 0) pause_burst();
      if (idle_on && $urandom_range(0, 24) == 0) wait_results();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_fields(CMD_LOAD, SLOT_W'($urandom_range(0, 1023)), $urandom,
                    PARAM_W'($urandom_range(0, 131071)));
      end else begin
        if (pick < 58) query_dist = $urandom_range(0, hi_end);
        else if (pick < 72) query_dist = plan_key[$urandom_range(0, n - 1)] +
                                         $urandom_range(0, 2) - 1;
        else if (pick < 82) query_dist = span31 + $urandom_range(0, 2) - 1;
        else if (pick < 92) query_dist = -$urandom_range(0, 32'h8000_0000);
        else query_dist = $urandom;
        send_fields(CMD_QUERY, SLOT_W'($urandom_range(0, 1023)), query_dist,
                    PARAM_W'($urandom_range(0, 131071)));
      end
    end
    settle();
    settings_run++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: span of zero, nothing loaded, so only the range checks answer.
    send_fields(CMD_QUERY, 10'd0, 32'h0000_0000, 17'd0);
    send_fields(CMD_QUERY, 10'h3FF, 32'h8000_0000, 17'h1FFFF);
    send_fields(CMD_QUERY, 10'd5, 32'h0000_0001, 17'd7);
    send_fields(CMD_QUERY, 10'd9, 32'h7FFF_FFFF, 17'd0);
    settle();

    write_reg(CFG_ENTRY_COUNT, 32'h0000_0000, 1'b0);
    write_reg(CFG_SPAN_LENGTH, 32'hFFFF_FFFF, 1'b0);
    send_fields(CMD_LOAD, 10'd0, 32'hFFFF_FFFB, 17'h1FFFF);
    send_fields(CMD_LOAD, 10'd1, 32'h7FFF_FFFF, 17'd0);
    send_fields(CMD_QUERY, 10'd0, 32'h4000_0000, 17'd0);
    send_fields(CMD_QUERY, 10'd0, 32'h0000_0001, 17'd0);
    send_fields(CMD_QUERY, 10'd0, 32'h7FFF_FFFE, 17'd0);
    send_fields(CMD_QUERY, 10'd0, 32'h7FFF_FFFF, 17'd0);
    send_fields(CMD_LOAD, 10'd1, 32'h8000_0000, 17'h1FFFF);
    send_fields(CMD_QUERY, 10'd0, 32'h0000_0005, 17'd0);
    send_fields(CMD_LOAD, 10'd0, 32'd1000, 17'd100);
    send_fields(CMD_LOAD, 10'd1, 32'd500, 17'd200);
    send_fields(CMD_QUERY, 10'd0, 32'd700, 17'd0);
    send_fields(CMD_LOAD, 10'h3FF, 32'h1234_5678, 17'd12345);
    settle();

    write_reg(CFG_ENTRY_COUNT, 32'h0000_0001, 1'b0);
    write_reg(CFG_SPAN_LENGTH, 32'h0010_0000, 1'b0);
    send_fields(CMD_LOAD, 10'd0, 32'h0000_1000, 17'd40000);
    send_fields(CMD_LOAD, 10'd1, 32'h0000_2000, 17'd1000);
    send_fields(CMD_QUERY, 10'd0, 32'h0000_0800, 17'd0);
    send_fields(CMD_QUERY, 10'd0, 32'h0000_3000, 17'd0);
    send_fields(CMD_QUERY, 10'd0, 32'h0000_1800, 17'd0);
    settle();

    while (load_beats + query_beats < ITEM_BUDGET) begin
      run_phase(pick_entry_count(), $urandom_range(15, 40), 1'b1);
    end
    run_phase({21'($urandom), 11'd12}, 40, 1'b0);

    $display("Ran %0d table settings with %0d load beats and %0d query beats,",
             settings_run + 3, load_beats, query_beats);
    $display("entry counts from below 2 up to 300, spans from 0 to the maximum.");
    if (check_errors == 0 && results_owed == 0) begin
      $display("table_inverse_interpolator regression: pass");
    end else begin
      $display("table_inverse_interpolator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+design
design/tii_pkg.sv
design/tii_ram.sv
design/tii_divider.sv
design/table_inverse_interpolator.sv
dv/table_inverse_interpolator_checker.sv
dv/table_inverse_interpolator_tb.sv
